// ===== sv/elevator_disk_request_scheduler_unit_defines.svh =====
// Assertion macros shared by the scheduler checker
`ifndef ELEVATOR_DISK_REQUEST_SCHEDULER_UNIT_DEFINES_SVH
`define ELEVATOR_DISK_REQUEST_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define EDRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edrs check failed");

// next-cycle implication, sampled on clk, off during reset
`define EDRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edrs check failed");

`endif

// ===== sv/edrs_pkg.sv =====
// Types, codes and defaults for the elevator disk request scheduler
package edrs_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int CYLINDERS_DEF   = 200;
    localparam int SECTORS_DEF     = 20;
    localparam int RECORDS_DEF     = 8;

    localparam logic KIND_ADD      = 1'b0;
    localparam logic KIND_SCHEDULE = 1'b1;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_SCHEDULED = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic       kind;
        logic [7:0] req_id;
        logic [7:0] cylinder;
        logic [4:0] sector;
        logic [3:0] record;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] sel_id;
        logic [7:0] sel_cylinder;
        logic [4:0] sel_sector;
        logic [2:0] sel_record;
        logic       moving_down;
        logic [7:0] pending;
    } out_t;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] cyl;
        logic [4:0] sec;
        logic [2:0] rec;
    } entry_t;

    typedef struct packed {
        entry_t pos;
        logic   arm_down;
        logic   first_pick;
    } head_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } scan_ctl_t;

    typedef struct packed {
        entry_t ent;
        logic   arm_down;
    } choice_t;

endpackage

// ===== sv/edrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module edrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/edrs_select.sv =====
// Candidate tracking over a table scan and final pick of the next request
module edrs_select #(
    parameter int TABLE_DEPTH = edrs_pkg::TABLE_DEPTH_DEF,
    parameter int SECTORS     = edrs_pkg::SECTORS_DEF,
    parameter int RECORDS     = edrs_pkg::RECORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  edrs_pkg::scan_ctl_t            ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0] idx,
    input  edrs_pkg::entry_t               ent,
    input  edrs_pkg::head_t                head,
    output logic [$clog2(TABLE_DEPTH)-1:0] sel_idx,
    output edrs_pkg::choice_t              choice
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int COST_W = $clog2(256 * SECTORS + 32 * RECORDS + 16) + 1;
    localparam int ROT_W  = $clog2(32 * RECORDS + SECTORS * RECORDS + 1) + 1;

    logic [COST_W-1:0] cost;
    logic [ROT_W-1:0]  here, there, rot_dist;

    logic              f_have_reg, s_have_reg, u_have_reg, d_have_reg;
    logic [COST_W-1:0] f_cost_reg;
    logic [ROT_W-1:0]  s_dist_reg;
    logic [IDX_W-1:0]  f_idx_reg, s_idx_reg, u_idx_reg, d_idx_reg;
    edrs_pkg::entry_t  f_ent_reg, s_ent_reg, u_ent_reg, d_ent_reg, z_ent_reg;

    logic take_f, take_s, take_u, take_d;

    always_comb
    begin
        cost  = COST_W'(ent.cyl) * COST_W'(SECTORS) + COST_W'(ent.sec) * COST_W'(RECORDS)
              + COST_W'(ent.rec);
        here  = ROT_W'(head.pos.sec) * ROT_W'(RECORDS) + ROT_W'(head.pos.rec);
        there = ROT_W'(ent.sec) * ROT_W'(RECORDS) + ROT_W'(ent.rec);
        // exact head position counts as a full revolution
        if (there > here)
        begin
            rot_dist = there - here;
        end
        else
        begin
            rot_dist = ROT_W'(SECTORS * RECORDS) - (here - there);
        end
        take_f = ctl.valid && (!f_have_reg || cost < f_cost_reg);
        take_s = ctl.valid && ent.cyl == head.pos.cyl
              && (!s_have_reg || rot_dist < s_dist_reg);
        take_u = ctl.valid && ent.cyl > head.pos.cyl
              && (!u_have_reg || ent.cyl <= u_ent_reg.cyl);
        take_d = ctl.valid && ent.cyl < head.pos.cyl
              && (!d_have_reg || ent.cyl >= d_ent_reg.cyl);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_have_reg <= 1'b0;
            s_have_reg <= 1'b0;
            u_have_reg <= 1'b0;
            d_have_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            f_have_reg <= 1'b0;
            s_have_reg <= 1'b0;
            u_have_reg <= 1'b0;
            d_have_reg <= 1'b0;
        end
        else
        begin
            f_have_reg <= f_have_reg | take_f;
            s_have_reg <= s_have_reg | take_s;
            u_have_reg <= u_have_reg | take_u;
            d_have_reg <= d_have_reg | take_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_f)
        begin
            f_cost_reg <= cost;
            f_idx_reg  <= idx;
            f_ent_reg  <= ent;
        end
        if (take_s)
        begin
            s_dist_reg <= rot_dist;
            s_idx_reg  <= idx;
            s_ent_reg  <= ent;
        end
        if (take_u)
        begin
            u_idx_reg <= idx;
            u_ent_reg <= ent;
        end
        if (take_d)
        begin
            d_idx_reg <= idx;
            d_ent_reg <= ent;
        end
        if (ctl.valid && idx == '0)
        begin
            z_ent_reg <= ent;
        end
    end

    always_comb
    begin
        sel_idx         = '0;
        choice.ent      = z_ent_reg;
        choice.arm_down = head.arm_down;
        if (head.first_pick)
        begin
            sel_idx    = f_idx_reg;
            choice.ent = f_ent_reg;
        end
        else if (s_have_reg)
        begin
            sel_idx    = s_idx_reg;
            choice.ent = s_ent_reg;
        end
        else if (!head.arm_down)
        begin
            if (u_have_reg)
            begin
                sel_idx    = u_idx_reg;
                choice.ent = u_ent_reg;
            end
            else
            begin
                choice.arm_down = 1'b1;
                if (d_have_reg)
                begin
                    sel_idx    = d_idx_reg;
                    choice.ent = d_ent_reg;
                end
            end
        end
        else
        begin
            if (d_have_reg)
            begin
                sel_idx    = d_idx_reg;
                choice.ent = d_ent_reg;
            end
            else
            begin
                choice.arm_down = 1'b0;
                if (u_have_reg)
                begin
                    sel_idx    = u_idx_reg;
                    choice.ent = u_ent_reg;
                end
            end
        end
    end

endmodule

// ===== sv/elevator_disk_request_scheduler_unit.sv =====
// Top level of the elevator disk request scheduler
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------
//  input    | start && !busy     | item   (edrs_pkg::in_t)
//  output   | done (one cycle)   | result (edrs_pkg::out_t)
//
// An add item, a range error, a full table or an empty schedule gives its result in the
// next cycle with busy staying low. A schedule item is scanned out of the RAM in S_SCAN
// (one entry per cycle through its single read port), picked in S_PICK, with the result
// shown in the cycle after, and the gap is then closed in S_SHIFT. Reset clears the count,
// head and direction; the RAM needs no clearing.
module elevator_disk_request_scheduler_unit #(
    parameter int TABLE_DEPTH = edrs_pkg::TABLE_DEPTH_DEF,
    parameter int CYLINDERS   = edrs_pkg::CYLINDERS_DEF,
    parameter int SECTORS     = edrs_pkg::SECTORS_DEF,
    parameter int RECORDS     = edrs_pkg::RECORDS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  edrs_pkg::in_t   item,
    output logic            busy,
    output logic            done,
    output edrs_pkg::out_t  result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_PICK  = 4'b0100,
        S_SHIFT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic                rv_reg, rv_next;
    logic [IDX_W-1:0]    rv_idx_reg, rv_idx_next;
    edrs_pkg::head_t     head_reg, head_next;
    logic                done_reg, done_next;
    edrs_pkg::out_t      result_reg, result_next;

    logic                we, re;
    logic [IDX_W-1:0]    waddr, raddr;
    edrs_pkg::entry_t    wdata, rdata;
    edrs_pkg::scan_ctl_t sctl;
    logic [IDX_W-1:0]    sel_idx;
    edrs_pkg::choice_t   choice;
    logic                accept, bad_range;
    logic [CNT_W-1:0]    last;

    edrs_ram #(
        .WIDTH ($bits(edrs_pkg::entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    edrs_select #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SECTORS     (SECTORS),
        .RECORDS     (RECORDS)
    ) u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sctl),
        .idx     (rv_idx_reg),
        .ent     (rdata),
        .head    (head_reg),
        .sel_idx (sel_idx),
        .choice  (choice)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign accept = start && !busy;
    assign last   = count_reg - CNT_W'(1);

    assign bad_range = (32'(item.cylinder) >= CYLINDERS) || (32'(item.sector) >= SECTORS)
                    || (32'(item.record) >= RECORDS);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        head_next   = head_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        we          = 1'b0;
        waddr       = count_reg[IDX_W-1:0];
        wdata       = '{id: item.req_id, cyl: item.cylinder, sec: item.sector,
                        rec: item.record[2:0]};
        re          = 1'b0;
        raddr       = ptr_reg[IDX_W-1:0];
        sctl.clear  = 1'b0;
        sctl.valid  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next               = 1'b1;
                    result_next             = '0;
                    result_next.moving_down = head_reg.arm_down;
                    result_next.pending     = 8'(count_reg);
                    if (item.kind == edrs_pkg::KIND_ADD)
                    begin
                        if (bad_range)
                        begin
                            result_next.status = edrs_pkg::ST_RANGE;
                        end
                        else if (count_reg >= CNT_W'(TABLE_DEPTH))
                        begin
                            result_next.status = edrs_pkg::ST_FULL;
                        end
                        else
                        begin
                            we                  = 1'b1;
                            count_next          = count_reg + CNT_W'(1);
                            result_next.status  = edrs_pkg::ST_ADDED;
                            result_next.pending = 8'(count_next);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        result_next.status = edrs_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        sctl.clear = 1'b1;
                        ptr_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                sctl.valid = rv_reg;
                if (ptr_reg < count_reg)
                begin
                    re       = 1'b1;
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (rv_reg && rv_idx_reg == last[IDX_W-1:0])
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                head_next.pos        = choice.ent;
                head_next.arm_down   = choice.arm_down;
                head_next.first_pick = 1'b0;
                count_next           = last;
                ptr_next             = CNT_W'(sel_idx) + CNT_W'(1);
                done_next            = 1'b1;
                result_next          = '{status: edrs_pkg::ST_SCHEDULED,
                                         sel_id: choice.ent.id,
                                         sel_cylinder: choice.ent.cyl,
                                         sel_sector: choice.ent.sec,
                                         sel_record: choice.ent.rec,
                                         moving_down: choice.arm_down,
                                         pending: 8'(last)};
                state_next           = S_SHIFT;
            end
            S_SHIFT:
            begin
                // read one above, write back one below
                if (ptr_reg <= count_reg)
                begin
                    re       = 1'b1;
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (rv_reg)
                begin
                    we    = 1'b1;
                    waddr = rv_idx_reg - IDX_W'(1);
                    wdata = rdata;
                end
                if (ptr_reg > count_reg && !rv_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rv_next     = re;
        rv_idx_next = re ? raddr : rv_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            rv_reg    <= 1'b0;
            head_reg  <= '{pos: '0, arm_down: 1'b0, first_pick: 1'b1};
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            rv_reg    <= rv_next;
            head_reg  <= head_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rv_idx_reg <= rv_idx_next;
        result_reg <= result_next;
    end

endmodule

// ===== sv/edrs_check.sv =====
// Port-level checker for the scheduler, bound to the top level
`include "elevator_disk_request_scheduler_unit_defines.svh"

module edrs_check (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input edrs_pkg::in_t  item,
    input logic           busy,
    input logic           done,
    input edrs_pkg::out_t result
);

    `EDRS_ASSERT_NEXT(a_accept_answered, start && !busy, done || busy)
    `EDRS_ASSERT_NOW(a_status_code, done, result.status == edrs_pkg::ST_ADDED || result.status == edrs_pkg::ST_RANGE || result.status == edrs_pkg::ST_FULL || result.status == edrs_pkg::ST_SCHEDULED || result.status == edrs_pkg::ST_EMPTY)
    `EDRS_ASSERT_NOW(a_sel_zero, done && result.status != edrs_pkg::ST_SCHEDULED, result.sel_id == 8'd0 && result.sel_cylinder == 8'd0 && result.sel_sector == 5'd0 && result.sel_record == 3'd0)
    `EDRS_ASSERT_NEXT(a_idle_quiet, !busy && !start, !done)

endmodule

bind elevator_disk_request_scheduler_unit edrs_check u_check (.*);
